// ===== src/chc_pkg.sv =====
`timescale 1ns / 1ps

package chc_pkg;

    localparam int PRESCALE   = 24;
    localparam int ANGLE_FRAC = 16;
    localparam int ACC_W      = 29;
    localparam int SPAN_W     = 20;
    localparam int HEAD_W     = 12;
    localparam int CNT_W      = 3;

    localparam logic [CNT_W-1:0] SEEN_FULL = 3'd4;
    localparam logic [SPAN_W-1:0] SPAN_RESET = 20'd16;
    localparam logic signed [ACC_W-1:0] HALF_TURN = 29'sd117964800;
    localparam logic signed [ACC_W-1:0] FULL_TURN = 29'sd235929600;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_SCALE,
        S_CORDIC,
        S_HOLD
    } top_state_t;

    typedef enum logic [1:0] {
        L_IDLE,
        L_MUL,
        L_DIV
    } lane_state_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_ITER,
        C_WRAP
    } cordic_state_t;

    // atan(2^-i) in 2^-16 tenth-degree units
    function automatic logic [ACC_W-1:0] atan_at(input logic [4:0] idx);
        logic [ACC_W-1:0] r;
        begin
            case (idx)
                5'd0:    r = 29'd29491200;
                5'd1:    r = 29'd17409672;
                5'd2:    r = 29'd9198793;
                5'd3:    r = 29'd4669451;
                5'd4:    r = 29'd2343786;
                5'd5:    r = 29'd1173036;
                5'd6:    r = 29'd586661;
                5'd7:    r = 29'd293348;
                5'd8:    r = 29'd146676;
                5'd9:    r = 29'd73339;
                5'd10:   r = 29'd36669;
                5'd11:   r = 29'd18335;
                5'd12:   r = 29'd9167;
                5'd13:   r = 29'd4584;
                5'd14:   r = 29'd2292;
                5'd15:   r = 29'd1146;
                5'd16:   r = 29'd573;
                5'd17:   r = 29'd286;
                5'd18:   r = 29'd143;
                5'd19:   r = 29'd72;
                5'd20:   r = 29'd36;
                5'd21:   r = 29'd18;
                5'd22:   r = 29'd9;
                5'd23:   r = 29'd4;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== src/chc_scale.sv =====
`timescale 1ns / 1ps

module chc_scale #(
    parameter int SAMPLE_BITS = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [SAMPLE_BITS+1:0] num,
    input  logic        [SAMPLE_BITS:0]   mul,
    input  logic        [SAMPLE_BITS-1:0] den,
    output logic                          done,
    output logic signed [SAMPLE_BITS+1:0] quo
);
    import chc_pkg::*;

    localparam int N  = SAMPLE_BITS;
    localparam int PW = 2 * N + 2;
    localparam int CW = $clog2(PW + 1);
    localparam logic [CW-1:0] MUL_LAST = CW'(N);
    localparam logic [CW-1:0] DIV_LAST = CW'(PW - 1);

    lane_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [N:0] mag_reg, mag_next;
    logic [N:0] mul_reg, mul_next;
    logic [N-1:0] den_reg, den_next;
    logic neg_reg, neg_next;
    logic [PW-1:0] acc_reg, acc_next;
    logic [N-1:0] rem_reg, rem_next;
    logic done_reg, done_next;
    logic signed [N+1:0] quo_reg, quo_next;
    logic [N:0] trial;
    logic ge;
    logic signed [N+1:0] num_abs;

    assign trial   = {rem_reg, acc_reg[PW-1]};
    assign ge      = trial >= {1'b0, den_reg};
    assign num_abs = num[N+1] ? -num : num;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            L_IDLE:  if (start) state_next = L_MUL;
            L_MUL:   if (cnt_reg == MUL_LAST) state_next = L_DIV;
            L_DIV:   if (cnt_reg == DIV_LAST) state_next = L_IDLE;
            default: state_next = L_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        mul_next  = mul_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        case (state_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    mag_next = num_abs[N:0];
                    neg_next = num[N+1];
                    mul_next = mul;
                    den_next = den;
                    acc_next = '0;
                    rem_next = '0;
                    cnt_next = '0;
                end
            end
            L_MUL:
            begin
                // shift-add, multiplier msb first
                acc_next = (acc_reg << 1) + (mul_reg[N] ? PW'(mag_reg) : '0);
                mul_next = mul_reg << 1;
                cnt_next = (cnt_reg == MUL_LAST) ? '0 : cnt_reg + 1'b1;
            end
            L_DIV:
            begin
                // restoring division, quotient bits shift in at the bottom
                rem_next = ge ? N'(trial - {1'b0, den_reg}) : trial[N-1:0];
                acc_next = {acc_reg[PW-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    done_next = 1'b1;
                    quo_next  = neg_reg ? -$signed(acc_next[N+1:0])
                                        : $signed(acc_next[N+1:0]);
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        mul_reg <= mul_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== src/chc_cordic.sv =====
`timescale 1ns / 1ps

module chc_cordic #(
    parameter int SAMPLE_BITS  = 20,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [SAMPLE_BITS+1:0] xc,
    input  logic signed [SAMPLE_BITS+1:0] yc,
    output logic                          done,
    output logic [chc_pkg::HEAD_W-1:0]    heading
);
    import chc_pkg::*;

    localparam int W  = SAMPLE_BITS + 28;
    localparam int IW = $clog2(CORDIC_STEPS + 1);
    localparam logic [IW-1:0] LAST = IW'(CORDIC_STEPS - 1);

    cordic_state_t state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic signed [W-1:0] u_reg, u_next, v_reg, v_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [HEAD_W-1:0] head_reg, head_next;
    logic done_reg, done_next;
    logic signed [W-1:0] u0, v0, du, dv;
    logic signed [ACC_W-1:0] step_angle, wrapped;
    logic is_zero;

    assign u0 = W'(xc) <<< PRESCALE;
    assign v0 = -(W'(yc) <<< PRESCALE);
    assign du = v_reg >>> idx_reg;
    assign dv = u_reg >>> idx_reg;
    assign step_angle = $signed(atan_at(5'(idx_reg)));
    assign is_zero = (xc == '0) && (yc == '0);

    always_comb
    begin
        if (acc_reg < 0)
            wrapped = acc_reg + FULL_TURN;
        else if (acc_reg >= FULL_TURN)
            wrapped = acc_reg - FULL_TURN;
        else
            wrapped = acc_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            C_IDLE:  if (start && !is_zero) state_next = C_ITER;
            C_ITER:  if (idx_reg == LAST) state_next = C_WRAP;
            C_WRAP:  state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    always_comb
    begin
        idx_next  = idx_reg;
        u_next    = u_reg;
        v_next    = v_reg;
        acc_next  = acc_reg;
        head_next = head_reg;
        done_next = 1'b0;
        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    idx_next = '0;
                    if (is_zero)
                    begin
                        head_next = '0;
                        done_next = 1'b1;
                    end
                    else if (u0 < 0)
                    begin
                        // left half plane: rotate by half a turn first
                        u_next   = -u0;
                        v_next   = -v0;
                        acc_next = HALF_TURN;
                    end
                    else
                    begin
                        u_next   = u0;
                        v_next   = v0;
                        acc_next = '0;
                    end
                end
            end
            C_ITER:
            begin
                if (v_reg >= 0)
                begin
                    u_next   = u_reg + du;
                    v_next   = v_reg - dv;
                    acc_next = acc_reg + step_angle;
                end
                else
                begin
                    u_next   = u_reg - du;
                    v_next   = v_reg + dv;
                    acc_next = acc_reg - step_angle;
                end
                idx_next = idx_reg + 1'b1;
            end
            C_WRAP:
            begin
                head_next = wrapped[ANGLE_FRAC+HEAD_W-1:ANGLE_FRAC];
                done_next = 1'b1;
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg    <= u_next;
        v_reg    <= v_next;
        acc_reg  <= acc_next;
        head_reg <= head_next;
    end

    assign done    = done_reg;
    assign heading = head_reg;

endmodule

// ===== src/compass_heading_with_auto_calibration.sv =====
`timescale 1ns / 1ps

// compass heading with min/max auto calibration
// input channel: in_valid/in_stall carries x_sample, y_sample, clear_first;
// a word is taken when in_valid is high and in_stall is low
// output channel: out_valid/out_stall carries heading_tenths and corrected,
// one word per input word, in order
// config channel: cfg_valid/cfg_ready writes min_span, always ready;
// write it only while no word is in flight
// one word is worked on at a time; in_stall is high from acceptance until
// the result is parked in the output register
// with correction: the bit-serial multiply lanes, then the bit-serial divide
// lanes, x and y in parallel, then one cordic iteration per cycle
// without correction: straight from the prep step to the cordic iterations
// a zero vector skips the cordic iterations
// the output register holds the result while out_stall is high; the next
// word may be accepted meanwhile and waits before its own result is loaded
// reset: min/max tracking cleared, sample count zero, min_span = 16

module compass_heading_with_auto_calibration #(
    parameter int SAMPLE_BITS  = 20,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [SAMPLE_BITS-1:0]    x_sample,
    input  logic signed [SAMPLE_BITS-1:0]    y_sample,
    input  logic                             clear_first,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [chc_pkg::HEAD_W-1:0]       heading_tenths,
    output logic                             corrected,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [chc_pkg::SPAN_W-1:0]       min_span
);
    import chc_pkg::*;

    localparam int N = SAMPLE_BITS;
    localparam logic signed [N-1:0] S_MAX = {1'b0, {(N-1){1'b1}}};
    localparam logic signed [N-1:0] S_MIN = {1'b1, {(N-1){1'b0}}};

    top_state_t state_reg, state_next;
    logic signed [N-1:0] lx_reg, lx_next, gx_reg, gx_next;
    logic signed [N-1:0] ly_reg, ly_next, gy_reg, gy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SPAN_W-1:0] span_reg;
    logic signed [N-1:0] x_reg, y_reg;
    logic corr_reg, corr_next;
    logic out_valid_reg;
    logic [HEAD_W-1:0] head_out_reg;
    logic corr_out_reg;

    logic accept, load_out;
    logic signed [N-1:0] lx_b, gx_b, ly_b, gy_b;
    logic [CNT_W-1:0] cnt_b;
    logic signed [N:0] sx_w, sy_w;
    logic [N-1:0] sx, sy;
    logic [N:0] s_sum;
    logic signed [N+1:0] nx, ny;
    logic do_corr;
    logic scale_start, cordic_start;
    logic x_done, y_done, cordic_done;
    logic signed [N+1:0] xq, yq, cx, cy;
    logic [HEAD_W-1:0] heading;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = state_reg != S_IDLE;
    assign cfg_ready = 1'b1;
    assign load_out  = (state_reg == S_HOLD) && (!out_valid_reg || !out_stall);

    // running min/max after this sample
    always_comb
    begin
        lx_b  = clear_first ? S_MAX : lx_reg;
        gx_b  = clear_first ? S_MIN : gx_reg;
        ly_b  = clear_first ? S_MAX : ly_reg;
        gy_b  = clear_first ? S_MIN : gy_reg;
        cnt_b = clear_first ? '0 : cnt_reg;
        lx_next  = (x_sample < lx_b) ? x_sample : lx_b;
        gx_next  = (x_sample > gx_b) ? x_sample : gx_b;
        ly_next  = (y_sample < ly_b) ? y_sample : ly_b;
        gy_next  = (y_sample > gy_b) ? y_sample : gy_b;
        cnt_next = (cnt_b < SEEN_FULL) ? cnt_b + 1'b1 : cnt_b;
    end

    assign sx_w  = (N+1)'(gx_reg) - (N+1)'(lx_reg);
    assign sy_w  = (N+1)'(gy_reg) - (N+1)'(ly_reg);
    assign sx    = sx_w[N-1:0];
    assign sy    = sy_w[N-1:0];
    assign s_sum = {1'b0, sx} + {1'b0, sy};
    assign nx    = ((N+2)'(x_reg) <<< 1) - (N+2)'(gx_reg) - (N+2)'(lx_reg);
    assign ny    = ((N+2)'(y_reg) <<< 1) - (N+2)'(gy_reg) - (N+2)'(ly_reg);
    assign do_corr = (cnt_reg >= SEEN_FULL)
                  && ({{(32-N){1'b0}}, sx} > {{(32-SPAN_W){1'b0}}, span_reg})
                  && ({{(32-N){1'b0}}, sy} > {{(32-SPAN_W){1'b0}}, span_reg});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (accept) state_next = S_PREP;
            S_PREP:   state_next = do_corr ? S_SCALE : S_CORDIC;
            S_SCALE:  if (x_done && y_done) state_next = S_CORDIC;
            S_CORDIC: if (cordic_done) state_next = S_HOLD;
            S_HOLD:   if (load_out) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        scale_start  = 1'b0;
        cordic_start = 1'b0;
        corr_next    = corr_reg;
        case (state_reg)
            S_PREP:
            begin
                corr_next    = do_corr;
                scale_start  = do_corr;
                cordic_start = !do_corr;
            end
            S_SCALE:
            begin
                cordic_start = x_done && y_done;
            end
            default:
            begin
                corr_next = corr_reg;
            end
        endcase
    end

    // cordic may start in the prep cycle, before corr_reg is loaded
    assign cx = corr_next ? xq : (N+2)'(x_reg);
    assign cy = corr_next ? yq : (N+2)'(y_reg);

    chc_scale #(.SAMPLE_BITS(N)) u_scale_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scale_start),
        .num   (nx),
        .mul   (s_sum),
        .den   (sx),
        .done  (x_done),
        .quo   (xq)
    );

    chc_scale #(.SAMPLE_BITS(N)) u_scale_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scale_start),
        .num   (ny),
        .mul   (s_sum),
        .den   (sy),
        .done  (y_done),
        .quo   (yq)
    );

    chc_cordic #(.SAMPLE_BITS(N), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .xc      (cx),
        .yc      (cy),
        .done    (cordic_done),
        .heading (heading)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lx_reg        <= S_MAX;
            gx_reg        <= S_MIN;
            ly_reg        <= S_MAX;
            gy_reg        <= S_MIN;
            cnt_reg       <= '0;
            span_reg      <= SPAN_RESET;
            corr_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            corr_reg  <= corr_next;
            if (accept)
            begin
                lx_reg  <= lx_next;
                gx_reg  <= gx_next;
                ly_reg  <= ly_next;
                gy_reg  <= gy_next;
                cnt_reg <= cnt_next;
            end
            if (cfg_valid && cfg_ready)
                span_reg <= min_span;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= x_sample;
            y_reg <= y_sample;
        end
        if (load_out)
        begin
            head_out_reg <= heading;
            corr_out_reg <= corr_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign heading_tenths = head_out_reg;
    assign corrected      = corr_out_reg;

endmodule
